### rtl/core/tama_pkg.sv
// shared types and constants of the three axis moving average block
package tama_pkg;

  // configuration register map
  localparam int unsigned CFG_LEN_BITS   = 12;
  localparam logic [CFG_LEN_BITS-1:0] WINDOW_RESET = 12'd2048;
  localparam logic        REG_WINDOW_LEN = 1'b0;  // register index 0

  // control from the sequencer to each axis lane
  typedef struct packed {
    logic load;   // latch the incoming sample
    logic rd;     // read the history entry at addr
    logic upd;    // update running total and write history
    logic full;   // window full: subtract the overwritten entry
    logic clear;  // clear the running total
    logic start;  // load the divider from the running total
    logic step;   // one divider iteration
  } lane_ctl_t;

endpackage

### rtl/core/tama_if.sv
// stream interfaces for sample input and average output
interface tama_sample_if #(parameter int W = 13);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_sample;
  logic signed [W-1:0] y_sample;
  logic signed [W-1:0] z_sample;

  modport source (output valid, x_sample, y_sample, z_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface tama_average_if #(parameter int W = 13);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x_average;
  logic signed [W-1:0] y_average;
  logic signed [W-1:0] z_average;

  modport source (output valid, x_average, y_average, z_average, input ready);
  modport sink   (input valid, x_average, y_average, z_average, output ready);
endinterface

### rtl/core/three_axis_moving_average.sv
// top level of the three axis moving average (boxcar) filter
//
//  channel   dir  handshake           payload
//  in_ch     in   valid/ready         x_sample, y_sample, z_sample
//  out_ch    out  valid/ready         x_average, y_average, z_average
//  apb       in   psel/penable/pready window_length at byte address 0
//
// from acceptance to result, each transaction passes through the bit-serial
// divider that each axis lane runs, one quotient bit per cycle
// the next sample is taken as soon as the result sits in the output register
// synchronous active-low reset clears sequencer, slot, fill count, totals and
// sets window_length to 2048; the history memories are not cleared
// a full output register with no ready stalls the hand-off of the next result and so holds off the next sample
module three_axis_moving_average #(
  parameter int MAX_WINDOW  = 2048,
  parameter int SAMPLE_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tama_sample_if.sink          in_ch,
  tama_average_if.source       out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tama_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int TW = SAMPLE_BITS + AW + 1;
  localparam int CW = $clog2(TW);
  localparam logic [CW-1:0] LAST_STEP = CW'(TW - 1);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a sample
    S_ACC,    // history entry read back, update totals
    S_START,  // load dividers
    S_DIV,    // divider iterations
    S_OUT     // hand averages to the output register
  } state_t;

  state_t                  state_r;
  logic [CFG_LEN_BITS-1:0] window_r;
  logic [AW-1:0]           slot_r;
  logic [LW-1:0]           fill_r;
  logic                    full_r;
  logic [CW-1:0]           step_r;

  logic [31:0]             win_ext;
  logic [LW-1:0]           eff_len;
  logic [AW-1:0]           slot_sel;
  logic [LW-1:0]           slot_inc;
  logic [AW-1:0]           mem_addr;
  logic                    accept;
  logic                    cfg_wr;
  logic                    can_load;
  lane_ctl_t               ctl;

  logic signed [SAMPLE_BITS-1:0] x_avg;
  logic signed [SAMPLE_BITS-1:0] y_avg;
  logic signed [SAMPLE_BITS-1:0] z_avg;

  // apb register port, pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
  assign prdata = (paddr[2] == REG_WINDOW_LEN) ?
                  {{(32-CFG_LEN_BITS){1'b0}}, window_r} : 32'd0;

  // a length of zero behaves as one, anything above the store depth as the depth
  assign win_ext = {{(32-CFG_LEN_BITS){1'b0}}, window_r};
  always_comb begin
    if (win_ext == 32'd0) begin
      eff_len = LW'(1);
    end else if (win_ext > 32'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(win_ext);
    end
  end

  // slot to overwrite; wraps to zero when the window shrank past it
  assign slot_sel = (LW'(slot_r) >= eff_len) ? '0 : slot_r;
  assign slot_inc = LW'(slot_r) + LW'(1);
  assign mem_addr = (state_r == S_IDLE) ? slot_sel : slot_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // lane control
  always_comb begin
    ctl       = '0;
    ctl.load  = accept;
    ctl.rd    = accept;
    ctl.upd   = (state_r == S_ACC);
    ctl.full  = full_r;
    ctl.clear = cfg_wr;
    ctl.start = (state_r == S_START);
    ctl.step  = (state_r == S_DIV);
  end

  // sequencer with slot, fill count and window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= WINDOW_RESET;
      slot_r   <= '0;
      fill_r   <= '0;
      full_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      if (cfg_wr) begin
        // new window length restarts averaging with an empty window
        window_r <= pwdata[CFG_LEN_BITS-1:0];
        slot_r   <= '0;
        fill_r   <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            slot_r  <= slot_sel;
            full_r  <= (fill_r >= eff_len);
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          // advance the write slot and grow the fill count until full
          slot_r  <= (slot_inc >= eff_len) ? '0 : slot_inc[AW-1:0];
          if (!full_r) begin
            fill_r <= fill_r + LW'(1);
          end
          state_r <= S_START;
        end
        S_START: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + CW'(1);
          if (step_r == LAST_STEP) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // one lane per axis, all sharing the sequencer's address and divisor
  tama_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .addr    (mem_addr),
    .divisor (fill_r),
    .sample  (in_ch.x_sample),
    .average (x_avg)
  );

  tama_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .addr    (mem_addr),
    .divisor (fill_r),
    .sample  (in_ch.y_sample),
    .average (y_avg)
  );

  tama_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .addr    (mem_addr),
    .divisor (fill_r),
    .sample  (in_ch.z_sample),
    .average (z_avg)
  );

  // merge the three lane results into one output transaction
  tama_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     ((state_r == S_OUT) && can_load),
    .x_avg    (x_avg),
    .y_avg    (y_avg),
    .z_avg    (z_avg),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### rtl/core/tama_lane.sv
// one axis lane: history memory, running total and iterative divider
module tama_lane #(
  parameter int SAMPLE_BITS = 13,
  parameter int MAX_WINDOW  = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tama_pkg::lane_ctl_t                    ctl,
  input  logic [$clog2(MAX_WINDOW)-1:0]          addr,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        divisor,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  output logic signed [SAMPLE_BITS-1:0]          average
);
  import tama_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int TW = SAMPLE_BITS + AW + 1;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [TW-1:0]          total_r;
  logic signed [TW-1:0]          total_nxt;
  logic signed [TW-1:0]          sample_ext;
  logic signed [TW-1:0]          old_ext;
  logic [TW-1:0]                 mag;
  logic [TW-1:0]                 quo_r;
  logic [LW-1:0]                 rem_r;
  logic                          neg_r;
  logic [LW:0]                   rem_sh;
  logic [LW:0]                   rem_sub;
  logic [SAMPLE_BITS-1:0]        q_low;

  // history store
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mem[addr] <= sample_r;
    end
    if (ctl.rd) begin
      old_r <= mem[addr];
    end
    if (ctl.load) begin
      sample_r <= sample;
    end
  end

  assign sample_ext = {{(TW-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign old_ext    = {{(TW-SAMPLE_BITS){old_r[SAMPLE_BITS-1]}}, old_r};
  assign total_nxt  = total_r + sample_ext - (ctl.full ? old_ext : {TW{1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      total_r <= '0;
    end else if (ctl.upd) begin
      total_r <= total_nxt;
    end
  end

  // restoring division of the magnitude, one quotient bit per step
  assign mag     = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
  assign rem_sh  = {rem_r, quo_r[TW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= mag;
      rem_r <= '0;
      neg_r <= total_r[TW-1];
    end else if (ctl.step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_r <= rem_sub[LW-1:0];
        quo_r <= {quo_r[TW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[LW-1:0];
        quo_r <= {quo_r[TW-2:0], 1'b0};
      end
    end
  end

  assign q_low   = quo_r[SAMPLE_BITS-1:0];
  assign average = neg_r ? $signed(-q_low) : $signed(q_low);

endmodule

### rtl/core/tama_merge.sv
// output stage: registers the three lane averages as one result transaction
module tama_merge #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] x_avg,
  input  logic signed [SAMPLE_BITS-1:0] y_avg,
  input  logic signed [SAMPLE_BITS-1:0] z_avg,
  output logic                          can_load,
  tama_average_if.source                out_ch
);
  import tama_pkg::*;

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [SAMPLE_BITS-1:0] z_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_avg;
      y_r <= y_avg;
      z_r <= z_avg;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.x_average = x_r;
  assign out_ch.y_average = y_r;
  assign out_ch.z_average = z_r;

endmodule

### bench/tb_three_axis_moving_average.sv
// self-checking bench for the three axis moving average filter
module tb_three_axis_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import tama_pkg::*;

  localparam int MAX_WINDOW  = 2048;
  localparam int SAMPLE_BITS = 13;
  // cycles to let pass once the result queue is empty, more than a sample
  // takes from acceptance to its average
  localparam int SETTLE      = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } triple_t;

  localparam sample_t S_MAX  = 13'sd4095;
  localparam sample_t S_MIN  = 13'h1000;
  localparam sample_t S_ZERO = 13'sd0;

  // byte addresses on the apb port: register i sits at 4*i
  localparam logic [2:0] ADDR_WINDOW   = 3'(4 * REG_WINDOW_LEN);
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_t;

  // one line of the directed table; ex/ey/ez are used only where typed is set
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] word;
    sample_t     x;
    sample_t     y;
    sample_t     z;
    logic        typed;
    sample_t     ex;
    sample_t     ey;
    sample_t     ez;
  } row_t;

  localparam int N_ROWS = 24;
  localparam row_t DIRECTED [N_ROWS] = '{
    // reset window of 2048: first sample averages to itself
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MIN, S_ZERO, 1'b1, S_MAX, S_MIN, S_ZERO},
    // opposite extremes cancel, -1/2 truncates to zero
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MIN, S_MAX, 13'sd1, 1'b1, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, 13'sd1, 13'sd2, -13'sd1, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    // window of one: output follows input
    '{ROW_WRITE, ADDR_WINDOW, 32'd1, S_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MAX, S_MAX, 1'b1, S_MAX, S_MAX, S_MAX},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MIN, S_MIN, S_MIN, 1'b1, S_MIN, S_MIN, S_MIN},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, 13'sd123, -13'sd77, S_ZERO,
      1'b1, 13'sd123, -13'sd77, S_ZERO},
    // zero length behaves as a window of one
    '{ROW_WRITE, ADDR_WINDOW, 32'd0, S_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, -13'sd1, 13'sd1, S_MIN, 1'b1, -13'sd1, 13'sd1, S_MIN},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, 13'sd2, 13'sd3, 13'sd4, 1'b1, 13'sd2, 13'sd3, 13'sd4},
    // window of two: negative sums truncate toward zero
    '{ROW_WRITE, ADDR_WINDOW, 32'd2, S_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, -13'sd1, -13'sd2, -13'sd3,
      1'b1, -13'sd1, -13'sd2, -13'sd3},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, -13'sd2, -13'sd2, -13'sd2,
      1'b1, -13'sd1, -13'sd2, -13'sd2},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MAX, S_MAX, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    // write to an unmapped register must not touch window or totals
    '{ROW_WRITE, ADDR_UNMAPPED, 32'd5, S_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MIN, S_MAX, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    // only the low 12 bits of the write data count
    '{ROW_WRITE, ADDR_WINDOW, 32'hFFFF_F003, S_ZERO, S_ZERO, S_ZERO,
      1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, 13'sd100, -13'sd100, 13'sd7, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MIN, S_MAX, -13'sd7, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MAX, S_MIN, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, 13'sd5, S_MIN, S_MIN, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    // length above the store size clamps to 2048
    '{ROW_WRITE, ADDR_WINDOW, 32'd4095, S_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, S_ZERO},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MAX, S_MAX, S_MAX, 1'b1, S_MAX, S_MAX, S_MAX},
    '{ROW_SAMPLE, ADDR_WINDOW, 32'd0, S_MIN, S_MIN, S_MIN, 1'b1, S_ZERO, S_ZERO, S_ZERO}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tama_sample_if  #(.W(SAMPLE_BITS)) smp ();
  tama_average_if #(.W(SAMPLE_BITS)) avg ();

  three_axis_moving_average #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (smp),
    .out_ch (avg),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // boxcar predictor: own copy of window setting, history, totals and counters
  // ---------------------------------------------------------------------------
  logic [11:0] window_setting;
  sample_t     history [3][MAX_WINDOW];
  longint      axis_total [3];
  int          next_slot;
  int          held_count;

  triple_t     averages_due [$];   // predicted averages, oldest first

  int          n_fail;
  int          n_samples;
  int          n_averages;
  int          n_windows;

  function automatic void restart_window();
    next_slot  = 0;
    held_count = 0;
    for (int a = 0; a < 3; a++) axis_total[a] = 0;
  endfunction

  // apply a register write as the block sees it
  function automatic void apply_write(logic [2:0] addr, logic [31:0] data);
    if ((addr >> 2) != 3'(REG_WINDOW_LEN)) return;
    window_setting = data[11:0];
    restart_window();
  endfunction

  // push one sample through the filter and return the three averages
  function automatic triple_t advance_boxcar(triple_t s);
    int      len;
    bit      full;
    sample_t v [3];
    longint  q;
    sample_t r [3];
    if (window_setting == 0)               len = 1;
    else if (window_setting > MAX_WINDOW)  len = MAX_WINDOW;
    else                                   len = int'(window_setting);
    full = held_count >= len;
    if (next_slot >= len) next_slot = 0;
    v[0] = s.x;
    v[1] = s.y;
    v[2] = s.z;
    for (int a = 0; a < 3; a++) begin
      axis_total[a] += v[a];
      // the overwritten entry leaves the total only once the window is full
      if (full) axis_total[a] -= history[a][next_slot];
      history[a][next_slot] = v[a];
    end
    next_slot++;
    if (next_slot >= len) next_slot = 0;
    if (!full) held_count++;
    if (held_count > len) held_count = len;
    for (int a = 0; a < 3; a++) begin
      q    = axis_total[a] / held_count;   // truncates toward zero
      r[a] = q[SAMPLE_BITS-1:0];
    end
    return {r[0], r[1], r[2]};
  endfunction

  // ---------------------------------------------------------------------------
  // result side: check every accepted transaction, stall in changing patterns
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_hold;

  task automatic check_average(triple_t got);
    triple_t want;
    if (averages_due.size() == 0) begin
      $error("unexpected average transaction x=%0d y=%0d z=%0d", got.x, got.y, got.z);
      n_fail++;
      return;
    end
    want = averages_due.pop_front();
    n_averages++;
    if (got.x !== want.x) begin
      $error("x_average: expected %0d, got %0d", want.x, got.x);
      n_fail++;
    end
    if (got.y !== want.y) begin
      $error("y_average: expected %0d, got %0d", want.y, got.y);
      n_fail++;
    end
    if (got.z !== want.z) begin
      $error("z_average: expected %0d, got %0d", want.z, got.z);
      n_fail++;
    end
  endtask

  initial begin
    avg.ready    = 1'b0;
    rx_mode      = RX_OPEN;
    rx_mode_left = 300;
    rx_hold      = 0;
  end

  always @(posedge clk) begin
    // values read here are the ones present at this edge
    if (rst_n && avg.valid && avg.ready)
      check_average({avg.x_average, avg.y_average, avg.z_average});

    // switch the stall pattern now and then
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(100, 400);
    end
    rx_mode_left--;

    case (rx_mode)
      RX_OPEN:   avg.ready <= 1'b1;
      RX_COIN:   avg.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: avg.ready <= ($urandom_range(0, 7) == 0);
      default: begin
        // long blocks of back-pressure
        if (rx_hold > 0) begin
          rx_hold--;
          avg.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(10, 50);
          avg.ready <= 1'b0;
        end else begin
          avg.ready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sample side and configuration port
  // ---------------------------------------------------------------------------
  int tx_burst_left;

  // offer one sample; returns at the edge where the transaction is taken
  task automatic send_sample(triple_t s, logic typed, triple_t typed_avg);
    triple_t predicted;
    if (tx_burst_left == 0) begin
      smp.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 60)) @(posedge clk);
      else                           repeat ($urandom_range(1, 4)) @(posedge clk);
      tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
    end
    tx_burst_left--;
    smp.valid    <= 1'b1;
    smp.x_sample <= s.x;
    smp.y_sample <= s.y;
    smp.z_sample <= s.z;
    do @(posedge clk); while (!smp.ready);
    predicted = advance_boxcar(s);
    averages_due.push_back(typed ? typed_avg : predicted);
    n_samples++;
  endtask

  // hold the input off until every predicted average has been taken
  task automatic drain_averages();
    smp.valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
  endtask

  // block quiet: nothing in flight, then some slack for the pipeline
  task automatic wait_idle();
    drain_averages();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_write(addr, data);
    n_windows++;
  endtask

  // read back the window length and compare with the predictor's copy
  task automatic check_window_reg();
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[11:0] !== window_setting) begin
      $error("window_length: expected %0d, got %0d", window_setting, got[11:0]);
      n_fail++;
    end
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // new window length, then a run of random samples
  task automatic run_phase(logic [31:0] word, int n_items);
    wait_idle();
    apb_write(ADDR_WINDOW, word);
    check_window_reg();
    for (int i = 0; i < n_items; i++) begin
      // mid-phase the sender holds off until the filter has caught up
      if (i == n_items / 2) drain_averages();
      send_sample({rand_sample(), rand_sample(), rand_sample()}, 1'b0, '0);
    end
  endtask

  initial begin
    row_t        row;
    logic [31:0] words [11];
    int          counts [11];

    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    smp.valid    <= 1'b0;
    smp.x_sample <= '0;
    smp.y_sample <= '0;
    smp.z_sample <= '0;
    n_fail        = 0;
    n_samples     = 0;
    n_averages    = 0;
    n_windows     = 0;
    tx_burst_left = 0;
    window_setting = WINDOW_RESET;
    restart_window();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the window register
    check_window_reg();

    // directed part
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        apb_write(row.addr, row.word);
        check_window_reg();
      end else begin
        send_sample({row.x, row.y, row.z}, row.typed, {row.ex, row.ey, row.ez});
      end
    end

    // random part: two runs at the largest window with large divisors,
    // the rest on shorter windows, most of which fill and wrap many times
    words  = '{32'd1, 32'd0, 32'd2, 32'd3,
               32'($urandom_range(4, 16)) | ($urandom & 32'hFFFF_F000),
               32'($urandom_range(17, 64)), 32'($urandom_range(65, 255)),
               32'd4095, 32'd2, 32'($urandom_range(5, 12)), 32'd2048};
    counts = '{40, 30, 50, 50, 80, 100, 150, 600, 30, 100, 100};
    for (int p = 0; p < 11; p++) run_phase(words[p], counts[p]);

    wait_idle();
    if (averages_due.size() != 0) begin
      $error("%0d predicted averages never arrived", averages_due.size());
      n_fail++;
    end

    $display("tb: %0d sample transactions, %0d average transactions compared",
             n_samples, n_averages);
    $display("tb: %0d register writes, windows from zero up to above the store size",
             n_windows);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
